### design/jvsl_pkg.sv
// shared types, constants and codes for the joint velocity slew limiter
// depends on nothing; every other file of the block imports it
package jvsl_pkg;

	// joint count the ports carry, and defaults of the top-level parameters
	localparam int NJ           = 6;
	localparam int JOINTS_DEF   = 6;
	localparam int MIN_GAP_DEF  = 20000;
	localparam int MAX_GAP_DEF  = 100000;

	// field widths
	localparam int VEL_W      = 16;
	localparam int LIM_W      = 15;
	localparam int ACC_W      = 16;
	localparam int TOUT_W     = 20;
	localparam int TIME_W     = 32;
	localparam int GAP_W      = 20;   // holds any gap up to the largest max gap
	localparam int SHIFT      = 20;   // delta limit = (accel * gap) >> 20
	localparam int PROD_W     = ACC_W + GAP_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VEL_LIMIT_0 = 3'd0,
		REG_VEL_LIMIT_1 = 3'd1,
		REG_VEL_LIMIT_2 = 3'd2,
		REG_VEL_LIMIT_3 = 3'd3,
		REG_VEL_LIMIT_4 = 3'd4,
		REG_VEL_LIMIT_5 = 3'd5,
		REG_ACCEL       = 3'd6,
		REG_TIMEOUT     = 3'd7
	} reg_idx_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_FWD    = 3'd0,
		ST_ZERO   = 3'd1,
		ST_ACCEPT = 3'd2,
		ST_SOON   = 3'd3,
		ST_GAP    = 3'd4,
		ST_SEED   = 3'd5
	} status_t;

	// what the front end decided about a word
	typedef enum logic [2:0] {
		CLS_TICK,
		CLS_SEED,
		CLS_SOON,
		CLS_GAP,
		CLS_SLEW
	} cls_t;

	typedef logic [NJ-1:0][LIM_W-1:0] lim_arr_t;
	typedef logic [NJ-1:0][VEL_W-1:0] vel_arr_t;

	localparam lim_arr_t        VEL_LIMIT_RST = {15'd1644, 15'd1644, 15'd1644,
		15'd1287, 15'd1072, 15'd1072};
	localparam logic [ACC_W-1:0]  ACCEL_RST   = 16'd3436;
	localparam logic [TOUT_W-1:0] TIMEOUT_RST = 20'd50000;

	// input word
	typedef struct packed {
		logic                     op;
		logic [TIME_W-1:0]        time_us;
		logic signed [VEL_W-1:0]  vel_0;
		logic signed [VEL_W-1:0]  vel_1;
		logic signed [VEL_W-1:0]  vel_2;
		logic signed [VEL_W-1:0]  vel_3;
		logic signed [VEL_W-1:0]  vel_4;
		logic signed [VEL_W-1:0]  vel_5;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [2:0]               status;
		logic signed [VEL_W-1:0]  cmd_0;
		logic signed [VEL_W-1:0]  cmd_1;
		logic signed [VEL_W-1:0]  cmd_2;
		logic signed [VEL_W-1:0]  cmd_3;
		logic signed [VEL_W-1:0]  cmd_4;
		logic signed [VEL_W-1:0]  cmd_5;
	} rsp_word_t;

	// control carried by the first pipeline stage
	typedef struct packed {
		cls_t              cls;
		logic [TIME_W-1:0] time_us;
		logic [GAP_W-1:0]  gap;
	} stage1_t;

	// control carried by the second pipeline stage, handed to the lanes and merge
	typedef struct packed {
		cls_t              cls;
		logic [TIME_W-1:0] time_us;
		logic [ACC_W-1:0]  step_lim;
	} stage2_t;

endpackage

### design/jvsl_if.sv
// valid/ready channels of the joint velocity slew limiter
// depends on jvsl_pkg for the word types
interface jvsl_req_if;
	import jvsl_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface jvsl_rsp_if;
	import jvsl_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/jvsl_regs.sv
// configuration registers: per-joint speed limits, accel limit, tick timeout
// depends on jvsl_pkg
module jvsl_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [jvsl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [jvsl_pkg::CFG_DATA_W-1:0]     cfg_data,
	output jvsl_pkg::lim_arr_t                  vel_limit,
	output logic [jvsl_pkg::ACC_W-1:0]          accel_limit,
	output logic [jvsl_pkg::TOUT_W-1:0]         timeout_us
);
	import jvsl_pkg::*;

	lim_arr_t           vel_limit_q;
	logic [ACC_W-1:0]   accel_q;
	logic [TOUT_W-1:0]  timeout_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_limit_q <= VEL_LIMIT_RST;
			accel_q     <= ACCEL_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx) inside
				[REG_VEL_LIMIT_0:REG_VEL_LIMIT_5]: begin
					vel_limit_q[cfg_idx] <= cfg_data[LIM_W-1:0];
				end
				REG_ACCEL: begin
					accel_q <= cfg_data[ACC_W-1:0];
				end
				REG_TIMEOUT: begin
					timeout_q <= cfg_data[TOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign vel_limit   = vel_limit_q;
	assign accel_limit = accel_q;
	assign timeout_us  = timeout_q;

endmodule

### design/jvsl_gate.sv
// front end: gap classification against the message clock, then the delta limit product
// depends on jvsl_pkg
module jvsl_gate #(
	parameter int unsigned MIN_GAP_US = jvsl_pkg::MIN_GAP_DEF,
	parameter int unsigned MAX_GAP_US = jvsl_pkg::MAX_GAP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  logic                          ld_s2,
	input  jvsl_pkg::req_word_t           word,
	input  logic [jvsl_pkg::ACC_W-1:0]    accel_limit,
	output jvsl_pkg::stage2_t             ctl_s2,
	output jvsl_pkg::vel_arr_t            vel_s2
);
	import jvsl_pkg::*;

	logic              seeded_q;
	logic [TIME_W-1:0] last_msg_q;
	logic [TIME_W-1:0] gap;
	cls_t              cls;
	stage1_t           ctl_s1;
	vel_arr_t          vel_s1;
	logic [PROD_W-1:0] prod;

	// classify the incoming word
	always_comb begin
		gap = word.time_us - last_msg_q;
		if (word.op) begin
			cls = CLS_TICK;
		end else if (!seeded_q) begin
			cls = CLS_SEED;
		end else if (gap < TIME_W'(MIN_GAP_US)) begin
			cls = CLS_SOON;
		end else if (gap > TIME_W'(MAX_GAP_US)) begin
			cls = CLS_GAP;
		end else begin
			cls = CLS_SLEW;
		end
	end

	// message clock: seeded by the first command, moved by every command not too soon
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q   <= 1'b0;
			last_msg_q <= '0;
		end else if (acc) begin
			if (cls == CLS_SEED) begin
				seeded_q <= 1'b1;
			end
			if (cls == CLS_SEED || cls == CLS_GAP || cls == CLS_SLEW) begin
				last_msg_q <= word.time_us;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.cls     <= cls;
			ctl_s1.time_us <= word.time_us;
			ctl_s1.gap     <= gap[GAP_W-1:0];
			vel_s1         <= {word.vel_5, word.vel_4, word.vel_3,
				word.vel_2, word.vel_1, word.vel_0};
		end
	end

	// delta limit product, only used when the gap is within the max gap
	assign prod = PROD_W'(accel_limit) * PROD_W'(ctl_s1.gap);

	// stage 2 register
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			ctl_s2.cls      <= ctl_s1.cls;
			ctl_s2.time_us  <= ctl_s1.time_us;
			ctl_s2.step_lim <= prod[SHIFT +: ACC_W];
			vel_s2          <= vel_s1;
		end
	end

endmodule

### design/jvsl_lane.sv
// one joint: speed clamp, slew clamp against the previous value, 16-bit saturation
// depends on jvsl_pkg
module jvsl_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  upd,
	input  jvsl_pkg::cls_t                        cls,
	input  logic [jvsl_pkg::VEL_W-1:0]            vel,
	input  logic [jvsl_pkg::LIM_W-1:0]            lim,
	input  logic [jvsl_pkg::ACC_W-1:0]            step_lim,
	output logic signed [jvsl_pkg::VEL_W-1:0]     lim_vel,
	output logic signed [jvsl_pkg::VEL_W-1:0]     cmd_vel
);
	import jvsl_pkg::*;

	logic signed [VEL_W-1:0] prev_q;
	logic signed [VEL_W-1:0] cmd_q;
	logic signed [VEL_W:0]   v_x;
	logic signed [VEL_W:0]   lim_x;
	logic signed [VEL_W:0]   q;
	logic signed [VEL_W+1:0] d;
	logic signed [VEL_W+1:0] md;
	logic signed [VEL_W+1:0] dc;
	logic signed [VEL_W+2:0] sum;

	// clamp to speed limit, then to +/- delta limit, then saturate
	always_comb begin
		v_x   = $signed({vel[VEL_W-1], vel});
		lim_x = $signed({1'b0, lim, 1'b0}) >>> 1;
		if (v_x > lim_x) begin
			q = lim_x;
		end else if (v_x < -lim_x) begin
			q = -lim_x;
		end else begin
			q = v_x;
		end
		d  = $signed({q[VEL_W], q}) - $signed({{2{prev_q[VEL_W-1]}}, prev_q});
		md = $signed({2'b00, step_lim});
		if (d > md) begin
			dc = md;
		end else if (d < -md) begin
			dc = -md;
		end else begin
			dc = d;
		end
		sum = $signed({dc[VEL_W+1], dc}) + $signed({{3{prev_q[VEL_W-1]}}, prev_q});
		if (sum > $signed(19'sd32767)) begin
			lim_vel = 16'sh7fff;
		end else if (sum < -$signed(19'sd32768)) begin
			lim_vel = 16'sh8000;
		end else begin
			lim_vel = sum[VEL_W-1:0];
		end
	end

	// slew history and stored command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cmd_q  <= '0;
		end else if (upd) begin
			if (cls == CLS_SLEW) begin
				prev_q <= lim_vel;
				cmd_q  <= lim_vel;
			end else if (cls == CLS_GAP) begin
				prev_q <= vel;
			end
		end
	end

	assign cmd_vel = cmd_q;

endmodule

### design/joint_velocity_slew_limiter.sv
// Joint velocity slew limiter with command watchdog. Takes one word per clock
// while the output side is not stalled; a word passes through the input register
// with gap classification, a stage for the accel-times-gap multiplier, then the
// joint lanes and merge into the output register. Each active joint has its own
// lane working in parallel on the same word; the merge stage picks the status and
// the watchdog state. Stalls on the output collapse bubbles stage by stage.
// Configuration must be written only while the block is idle; nothing enforces it.
// depends on jvsl_pkg, jvsl_if, jvsl_regs, jvsl_gate, jvsl_lane
module joint_velocity_slew_limiter #(
	parameter int          JOINTS     = jvsl_pkg::JOINTS_DEF,
	parameter int unsigned MIN_GAP_US = jvsl_pkg::MIN_GAP_DEF,
	parameter int unsigned MAX_GAP_US = jvsl_pkg::MAX_GAP_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	jvsl_req_if.sink                          req,
	jvsl_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [jvsl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [jvsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import jvsl_pkg::*;

	lim_arr_t            vel_limit;
	logic [ACC_W-1:0]    accel_limit;
	logic [TOUT_W-1:0]   timeout_us;
	logic                vld_s1;
	logic                vld_s2;
	logic                out_vld_q;
	logic                out_en;
	logic                en_s2;
	logic                en_s1;
	logic                acc;
	logic                ld_s2;
	logic                ld_out;
	stage2_t             ctl_s2;
	vel_arr_t            vel_s2;
	logic signed [VEL_W-1:0] lim_vel [NJ];
	logic signed [VEL_W-1:0] cmd_vel [NJ];
	logic signed [VEL_W-1:0] out_cmd [NJ];
	logic                cmd_valid_q;
	logic [TIME_W-1:0]   last_cmd_q;
	logic [TIME_W-1:0]   age;
	logic                fresh;
	status_t             status;
	rsp_word_t           rsp_q;

	jvsl_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.vel_limit   (vel_limit),
		.accel_limit (accel_limit),
		.timeout_us  (timeout_us)
	);

	// stage handshake: each stage moves when the one after it is empty or moving
	assign out_en    = !out_vld_q || rsp.ready;
	assign en_s2     = !vld_s2 || out_en;
	assign en_s1     = !vld_s1 || en_s2;
	assign req.ready = en_s1;
	assign acc       = req.valid && en_s1;
	assign ld_s2     = vld_s1 && en_s2;
	assign ld_out    = vld_s2 && out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= req.valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (out_en) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	jvsl_gate #(
		.MIN_GAP_US (MIN_GAP_US),
		.MAX_GAP_US (MAX_GAP_US)
	) u_gate (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.ld_s2       (ld_s2),
		.word        (req.payload),
		.accel_limit (accel_limit),
		.ctl_s2      (ctl_s2),
		.vel_s2      (vel_s2)
	);

	// one lane per active joint; unused joints read as zero
	for (genvar j = 0; j < NJ; j++) begin : g_lane
		if (j < JOINTS) begin : g_on
			jvsl_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.upd       (ld_out),
				.cls       (ctl_s2.cls),
				.vel       (vel_s2[j]),
				.lim       (vel_limit[j]),
				.step_lim  (ctl_s2.step_lim),
				.lim_vel   (lim_vel[j]),
				.cmd_vel   (cmd_vel[j])
			);
		end else begin : g_off
			assign lim_vel[j] = '0;
			assign cmd_vel[j] = '0;
		end
	end

	// merge: status and joint values for the word in stage 2
	always_comb begin
		age   = ctl_s2.time_us - last_cmd_q;
		fresh = cmd_valid_q && (age < TIME_W'(timeout_us));
		for (int j = 0; j < NJ; j++) begin
			out_cmd[j] = '0;
		end
		case (ctl_s2.cls)
			CLS_TICK: begin
				if (fresh) begin
					status = ST_FWD;
					for (int j = 0; j < NJ; j++) begin
						out_cmd[j] = cmd_vel[j];
					end
				end else begin
					status = ST_ZERO;
				end
			end
			CLS_SEED: status = ST_SEED;
			CLS_SOON: status = ST_SOON;
			CLS_GAP:  status = ST_GAP;
			CLS_SLEW: begin
				status = ST_ACCEPT;
				for (int j = 0; j < NJ; j++) begin
					out_cmd[j] = lim_vel[j];
				end
			end
			default: status = ST_ZERO;
		endcase
	end

	// watchdog state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			last_cmd_q  <= '0;
		end else if (ld_out) begin
			if (ctl_s2.cls == CLS_SLEW) begin
				cmd_valid_q <= 1'b1;
				last_cmd_q  <= ctl_s2.time_us;
			end else if (ctl_s2.cls == CLS_GAP || (ctl_s2.cls == CLS_TICK && !fresh)) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			rsp_q.status <= status;
			rsp_q.cmd_0  <= out_cmd[0];
			rsp_q.cmd_1  <= out_cmd[1];
			rsp_q.cmd_2  <= out_cmd[2];
			rsp_q.cmd_3  <= out_cmd[3];
			rsp_q.cmd_4  <= out_cmd[4];
			rsp_q.cmd_5  <= out_cmd[5];
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = rsp_q;

endmodule

### design/jvsl_chk.sv
// port-level checks of the joint velocity slew limiter, bound to the top level
// depends on jvsl_pkg and joint_velocity_slew_limiter
module jvsl_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  jvsl_pkg::rsp_word_t rsp_payload
);
	import jvsl_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result word changed while stalled");

	// only forwarded or accepted words carry joint values
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != ST_FWD && rsp_payload.status != ST_ACCEPT
		|-> rsp_payload.cmd_0 == 0 && rsp_payload.cmd_1 == 0 && rsp_payload.cmd_2 == 0
		&& rsp_payload.cmd_3 == 0 && rsp_payload.cmd_4 == 0 && rsp_payload.cmd_5 == 0)
		else $error("nonzero joint value on a status without a command");

	// an accepted word reaches the output while the output is not stalled
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
		else $error("result word did not arrive");

	// an empty output never holds back input
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty output");

endmodule

bind joint_velocity_slew_limiter jvsl_chk u_jvsl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
